[sv/dpid_pkg.sv]
// Shared types, widths and codes for the differential drive PID unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package dpid_pkg;

    // Field and datapath widths
    localparam int POS_W       = 24;
    localparam int ERR_W       = POS_W + 1;
    localparam int DER_W       = ERR_W + 1;
    localparam int INTEG_W     = 26;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 23;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 23;
    localparam int PROD_W      = DER_W + GAIN_W + 1;
    localparam int POWER_W     = PROD_W + 2;
    localparam int MIX_W       = POWER_W + 1;
    localparam int DRIVE_W     = 13;
    localparam int DRIVE_MAX   = 3072;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LAT_P,
        CFG_LAT_I,
        CFG_LAT_D,
        CFG_TURN_P,
        CFG_TURN_I,
        CFG_TURN_D,
        CFG_WINDOW,
        CFG_LIMIT
    } t_cfg_index;

    // Gain set of one loop, unsigned Q8.8
    typedef struct packed {
        logic [GAIN_W-1:0] p;
        logic [GAIN_W-1:0] i;
        logic [GAIN_W-1:0] d;
    } t_gains;

    // Error terms of one loop handed from the error stage to the multiply stage
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DER_W-1:0]   der;
        logic signed [INTEG_W-1:0] integ;
    } t_loop_terms;

    // Stage load strobes for the multiply-accumulate unit
    typedef struct packed {
        logic prod;
        logic power;
    } t_mac_load;

endpackage

[sv/dpid_err.sv]
// Error stage of one PID loop: error, derivative and clamped integral.
// Holds the loop state (previous error, integral); depends on dpid_pkg.
`timescale 1ns / 1ps

module dpid_err (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic signed [dpid_pkg::POS_W-1:0] i_meas,
    input  logic signed [dpid_pkg::POS_W-1:0] i_target,
    input  logic [dpid_pkg::LIMIT_W-1:0]      i_window,
    input  logic [dpid_pkg::LIMIT_W-1:0]      i_limit,
    output dpid_pkg::t_loop_terms             o_terms
);
    import dpid_pkg::*;

    logic signed [ERR_W-1:0]   r_err,   n_err;
    logic signed [DER_W-1:0]   r_der,   n_der;
    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic [ERR_W-1:0]          err_mag;
    logic                      in_window;
    logic signed [INTEG_W:0]   acc_sum;
    logic signed [INTEG_W:0]   lim_pos;
    logic signed [INTEG_W:0]   lim_neg;

    // Error and derivative against the previous error of this loop
    always_comb begin
        n_err = ERR_W'(i_meas) - ERR_W'(i_target);
        n_der = DER_W'(n_err) - DER_W'(r_err);
    end

    // Accumulate inside the window, otherwise drop the integral, then clamp
    always_comb begin
        err_mag   = n_err[ERR_W-1] ? ERR_W'(-n_err) : ERR_W'(n_err);
        in_window = err_mag < {{(ERR_W-LIMIT_W){1'b0}}, i_window};
        lim_pos   = $signed({{(INTEG_W+1-LIMIT_W){1'b0}}, i_limit});
        lim_neg   = -lim_pos;
        if (in_window) begin
            acc_sum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(n_err);
        end else begin
            acc_sum = '0;
        end
        if (acc_sum > lim_pos) begin
            n_integ = INTEG_W'(lim_pos);
        end else if (acc_sum < lim_neg) begin
            n_integ = INTEG_W'(lim_neg);
        end else begin
            n_integ = INTEG_W'(acc_sum);
        end
    end

    // Advance loop state once per transfer into this stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err   <= '0;
            r_der   <= '0;
            r_integ <= '0;
        end else if (i_load) begin
            r_err   <= n_err;
            r_der   <= n_der;
            r_integ <= n_integ;
        end
    end

    assign o_terms.err   = r_err;
    assign o_terms.der   = r_der;
    assign o_terms.integ = r_integ;

endmodule

[sv/dpid_mac.sv]
// Multiply-accumulate of one PID loop: three gain products, then their sum.
// Two register stages, no reset on payload; depends on dpid_pkg.
`timescale 1ns / 1ps

module dpid_mac (
    input  logic                                i_clk,
    input  dpid_pkg::t_mac_load                 i_load,
    input  dpid_pkg::t_loop_terms               i_terms,
    input  dpid_pkg::t_gains                    i_gains,
    output logic signed [dpid_pkg::POWER_W-1:0] o_power
);
    import dpid_pkg::*;

    logic signed [ERR_W-1:0]   term_err;
    logic signed [DER_W-1:0]   term_der;
    logic signed [INTEG_W-1:0] term_integ;
    logic signed [GAIN_W:0]    gain_p;
    logic signed [GAIN_W:0]    gain_i;
    logic signed [GAIN_W:0]    gain_d;
    logic signed [PROD_W-1:0]  n_prod_p, n_prod_i, n_prod_d;
    logic signed [PROD_W-1:0]  r_prod_p, r_prod_i, r_prod_d;
    logic signed [POWER_W-1:0] n_power, r_power;

    // Gains are unsigned: widen with a zero sign bit
    always_comb begin
        term_err   = i_terms.err;
        term_der   = i_terms.der;
        term_integ = i_terms.integ;
        gain_p     = $signed({1'b0, i_gains.p});
        gain_i     = $signed({1'b0, i_gains.i});
        gain_d     = $signed({1'b0, i_gains.d});
        n_prod_p   = term_err * gain_p;
        n_prod_d   = term_der * gain_d;
        n_prod_i   = term_integ * gain_i;
    end

    // Register the products
    always_ff @(posedge i_clk) begin
        if (i_load.prod) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
        end
    end

    // Sum into the loop power, signed Q37.8 volts
    assign n_power = POWER_W'(r_prod_p) + POWER_W'(r_prod_d) + POWER_W'(r_prod_i);

    always_ff @(posedge i_clk) begin
        if (i_load.power) begin
            r_power <= n_power;
        end
    end

    assign o_power = r_power;

endmodule

[sv/differential_drive_pid_unit.sv]
// Top level of the differential drive PID unit: config registers, input stage,
// pipeline control, drive mixing and saturation. Uses dpid_err, dpid_mac, dpid_pkg.
// An item passes the input, error, product, sum and result registers in turn.
// Throughput: one item per cycle while no result is held; five register stages with
// per-stage valid bits, so a held result stalls only once every stage is full.
// Reset (synchronous, active low) clears valid bits, gains, window, limit,
// both previous errors and both integrals.
`timescale 1ns / 1ps

module differential_drive_pid_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [dpid_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [dpid_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // input channel
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [dpid_pkg::POS_W-1:0]      i_left_position,
    input  logic signed [dpid_pkg::POS_W-1:0]      i_right_position,
    input  logic signed [dpid_pkg::POS_W-1:0]      i_heading,
    input  logic signed [dpid_pkg::POS_W-1:0]      i_distance_target,
    input  logic signed [dpid_pkg::POS_W-1:0]      i_heading_target,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [dpid_pkg::DRIVE_W-1:0]    o_left_drive,
    output logic signed [dpid_pkg::DRIVE_W-1:0]    o_right_drive
);
    import dpid_pkg::*;

    // Clamp a mixed drive to the voltage bound
    function automatic logic signed [DRIVE_W-1:0] sat_drive(logic signed [MIX_W-1:0] v);
        logic signed [MIX_W-1:0] hi;
        logic signed [MIX_W-1:0] lo;
        hi = MIX_W'(DRIVE_MAX);
        lo = -hi;
        if (v > hi) begin
            sat_drive = DRIVE_W'(hi);
        end else if (v < lo) begin
            sat_drive = DRIVE_W'(lo);
        end else begin
            sat_drive = DRIVE_W'(v);
        end
    endfunction

    t_gains               r_lat_gains, r_turn_gains;
    logic [LIMIT_W-1:0]   r_window, r_limit;

    logic                 r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_out_valid;
    logic                 ld_a, ld_b, ld_c, ld_d, ld_out;

    logic signed [POS_W:0]     wheel_sum, wheel_adj;
    logic signed [POS_W-1:0]   n_mean;
    logic signed [POS_W-1:0]   r_mean, r_dist_tgt, r_head, r_head_tgt;

    t_loop_terms               lat_terms, turn_terms;
    t_mac_load                 mac_load;
    logic signed [POWER_W-1:0] lat_power, turn_power;
    logic signed [MIX_W-1:0]   mix_left, mix_right;
    logic signed [DRIVE_W-1:0] r_left_drive, r_right_drive;

    // Configuration writes; narrow registers drop the upper data bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_gains  <= '0;
            r_turn_gains <= '0;
            r_window     <= '0;
            r_limit      <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LAT_P:  r_lat_gains.p  <= i_cfg_data[GAIN_W-1:0];
                CFG_LAT_I:  r_lat_gains.i  <= i_cfg_data[GAIN_W-1:0];
                CFG_LAT_D:  r_lat_gains.d  <= i_cfg_data[GAIN_W-1:0];
                CFG_TURN_P: r_turn_gains.p <= i_cfg_data[GAIN_W-1:0];
                CFG_TURN_I: r_turn_gains.i <= i_cfg_data[GAIN_W-1:0];
                CFG_TURN_D: r_turn_gains.d <= i_cfg_data[GAIN_W-1:0];
                CFG_WINDOW: r_window       <= i_cfg_data[LIMIT_W-1:0];
                CFG_LIMIT:  r_limit        <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage loads: a stage takes new data when empty or when it drains
    always_comb begin
        ld_out  = !r_out_valid || i_ready;
        ld_d    = !r_d_valid || ld_out;
        ld_c    = !r_c_valid || ld_d;
        ld_b    = !r_b_valid || ld_c;
        ld_a    = !r_a_valid || ld_b;
        o_ready = ld_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ld_a)   r_a_valid   <= i_valid;
            if (ld_b)   r_b_valid   <= r_a_valid;
            if (ld_c)   r_c_valid   <= r_b_valid;
            if (ld_d)   r_d_valid   <= r_c_valid;
            if (ld_out) r_out_valid <= r_d_valid;
        end
    end

    // Wheel mean, halved with truncation toward zero
    always_comb begin
        wheel_sum = (POS_W+1)'(i_left_position) + (POS_W+1)'(i_right_position);
        wheel_adj = wheel_sum + $signed({{POS_W{1'b0}}, wheel_sum[POS_W]});
        n_mean    = wheel_adj[POS_W:1];
    end

    // Input stage: capture the transfer
    always_ff @(posedge i_clk) begin
        if (ld_a) begin
            r_mean     <= n_mean;
            r_dist_tgt <= i_distance_target;
            r_head     <= i_heading;
            r_head_tgt <= i_heading_target;
        end
    end

    // Error stage: loop state advances only on a real item
    dpid_err u_lat_err (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (ld_b && r_a_valid),
        .i_meas   (r_mean),
        .i_target (r_dist_tgt),
        .i_window (r_window),
        .i_limit  (r_limit),
        .o_terms  (lat_terms)
    );

    dpid_err u_turn_err (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (ld_b && r_a_valid),
        .i_meas   (r_head),
        .i_target (r_head_tgt),
        .i_window (r_window),
        .i_limit  (r_limit),
        .o_terms  (turn_terms)
    );

    // Product and sum stages
    always_comb begin
        mac_load.prod  = ld_c;
        mac_load.power = ld_d;
    end

    dpid_mac u_lat_mac (
        .i_clk   (i_clk),
        .i_load  (mac_load),
        .i_terms (lat_terms),
        .i_gains (r_lat_gains),
        .o_power (lat_power)
    );

    dpid_mac u_turn_mac (
        .i_clk   (i_clk),
        .i_load  (mac_load),
        .i_terms (turn_terms),
        .i_gains (r_turn_gains),
        .o_power (turn_power)
    );

    // Mix lateral and turn, saturate, hold in the result register
    always_comb begin
        mix_left  = MIX_W'(lat_power) - MIX_W'(turn_power);
        mix_right = MIX_W'(lat_power) + MIX_W'(turn_power);
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_left_drive  <= sat_drive(mix_left);
            r_right_drive <= sat_drive(mix_right);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_left_drive  = r_left_drive;
    assign o_right_drive = r_right_drive;

endmodule

[sv/dpid_checker.sv]
// Port-level checks for the differential drive PID unit, bound to the top level.
// Sees only the top-level ports; depends on dpid_pkg.
`timescale 1ns / 1ps

module dpid_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dpid_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [dpid_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    input  logic                                o_ready,
    input  logic signed [dpid_pkg::POS_W-1:0]   i_left_position,
    input  logic signed [dpid_pkg::POS_W-1:0]   i_right_position,
    input  logic signed [dpid_pkg::POS_W-1:0]   i_heading,
    input  logic signed [dpid_pkg::POS_W-1:0]   i_distance_target,
    input  logic signed [dpid_pkg::POS_W-1:0]   i_heading_target,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic signed [dpid_pkg::DRIVE_W-1:0] o_left_drive,
    input  logic signed [dpid_pkg::DRIVE_W-1:0] o_right_drive
);
    import dpid_pkg::*;

    localparam logic signed [DRIVE_W-1:0] DRV_HI = DRIVE_W'(DRIVE_MAX);
    localparam logic signed [DRIVE_W-1:0] DRV_LO = DRIVE_W'(-DRIVE_MAX);

    // Hold a result until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_left_drive) && $stable(o_right_drive))
        else $error("stalled result changed");

    // Drives stay inside the voltage bound
    a_drive_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_drive <= DRV_HI) && (o_left_drive >= DRV_LO) &&
                    (o_right_drive <= DRV_HI) && (o_right_drive >= DRV_LO))
        else $error("drive outside saturation bound");

    // Input stalls only while a result waits on the output side
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without output backpressure");

endmodule

bind differential_drive_pid_unit dpid_checker u_dpid_checker (.*);
